// ===== rtl/core/q24_alu_pkg.sv =====
// types and constants shared by the q24.8 fixed-point alu
// no dependencies
`timescale 1ns / 1ps

package q24_alu_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_LT       = 4'd4,
      OP_GT       = 4'd5,
      OP_LE       = 4'd6,
      OP_GE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   // per-item data that travels beside the multiplier and divider
   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0] value;
      logic                      compare_true;
      logic                      divide_by_zero;
   } side_type;

endpackage

// ===== rtl/core/q24_alu_if.sv =====
// request and response channel interfaces of the q24.8 fixed-point alu
// depends on q24_alu_pkg
`timescale 1ns / 1ps

interface q24_alu_req_if;
   import q24_alu_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic signed [DATA_W-1:0]  operand_a;
   logic signed [DATA_W-1:0]  operand_b;
   modport source (output valid, op, operand_a, operand_b, input ready);
   modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface q24_alu_rsp_if;
   import q24_alu_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  result_value;
   logic                      compare_true;
   logic                      divide_by_zero;
   modport source (output valid, result_value, compare_true, divide_by_zero,
                   input ready);
   modport sink   (input valid, result_value, compare_true, divide_by_zero,
                   output ready);
endinterface

// ===== rtl/core/q24_alu_mul.sv =====
// two-stage signed multiplier with arithmetic fraction shift
// depends on q24_alu_pkg
`timescale 1ns / 1ps

module q24_alu_mul
   import q24_alu_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [DATA_W-1:0]  a,
   input  logic signed [DATA_W-1:0]  b,
   output logic signed [DATA_W-1:0]  product
);

   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [2*DATA_W-1:0] prod_in;
   logic signed [DATA_W-1:0]   shift_ff;
   logic signed [2*DATA_W-1:0] shift_full;
   logic signed [DATA_W-1:0]   shift_in;

   always_comb begin
      prod_in    = a * b;
      shift_full = prod_ff >>> FRACTION_BITS;
      shift_in   = shift_full[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         shift_ff <= shift_in;
      end
   end

   assign product = shift_ff;

endmodule

// ===== rtl/core/q24_alu_div.sv =====
// pipelined restoring divider, one quotient bit per stage, signed truncating
// depends on q24_alu_pkg
`timescale 1ns / 1ps

module q24_alu_div
   import q24_alu_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [DATA_W-1:0]  a,
   input  logic signed [DATA_W-1:0]  b,
   output logic signed [DATA_W-1:0]  quotient
);

   localparam int DW = DATA_W + FRACTION_BITS;

   logic [DW-1:0]     dvd_ff [0:DW];
   logic [DATA_W-1:0] rem_ff [0:DW];
   logic [DATA_W-1:0] dsr_ff [0:DW];
   logic              neg_ff [0:DW];

   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] mag_b;
   logic [DW-1:0]     q_neg;
   logic [DATA_W-1:0] quot_in;
   logic [DATA_W-1:0] quot_ff;

   always_comb begin
      mag_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
      mag_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dvd_ff[0] <= {mag_a, {FRACTION_BITS{1'b0}}};
         rem_ff[0] <= '0;
         dsr_ff[0] <= mag_b;
         neg_ff[0] <= a[DATA_W-1] ^ b[DATA_W-1];
      end
   end

   for (genvar i = 0; i < DW; i++) begin : g_stage
      logic [DATA_W:0]   trial;
      logic [DATA_W:0]   diff;
      logic              take;
      logic [DATA_W-1:0] rem_in;
      logic [DW-1:0]     dvd_in;

      always_comb begin
         trial  = {rem_ff[i], dvd_ff[i][DW-1]};
         diff   = trial - {1'b0, dsr_ff[i]};
         take   = !diff[DATA_W];
         rem_in = take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         dvd_in = {dvd_ff[i][DW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvd_ff[i+1] <= dvd_in;
            rem_ff[i+1] <= rem_in;
            dsr_ff[i+1] <= dsr_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_comb begin
      q_neg   = -dvd_ff[DW];
      quot_in = neg_ff[DW] ? q_neg[DATA_W-1:0] : dvd_ff[DW][DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quotient = quot_ff;

endmodule

// ===== rtl/core/fixed_point_q24_8_alu.sv =====
// top level of the q24.8 fixed-point alu: request decode, side pipeline, output
// depends on q24_alu_pkg, q24_alu_if, q24_alu_mul, q24_alu_div
`timescale 1ns / 1ps

// Usage: a request on req_chan carries op, operand_a and operand_b; each
// request gives exactly one response on rsp_chan with result_value,
// compare_true and divide_by_zero, in request order.
// Both channels use valid/ready; a transfer happens on a clock edge where
// both are high.
// Every operation has the same latency, set by the divider: one input
// register, one stage per quotient bit (32 + FRACTION_BITS) and one
// sign-fix register. All other operations ride alongside in a side
// pipeline of the same depth.
// Throughput is one request per cycle while rsp_chan does not stall.
// When the receiver holds rsp_chan.ready low while a response is shown, the
// whole pipeline freezes and req_chan.ready drops; nothing is lost or
// repeated.
// Reset (synchronous, active high) clears all valid bits; no clearing pass.

module fixed_point_q24_8_alu
   import q24_alu_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   q24_alu_req_if.sink      req_chan,
   q24_alu_rsp_if.source    rsp_chan
);

   localparam int DEPTH   = DATA_W + FRACTION_BITS + 2;
   localparam int MUL_LAT = 2;

   logic     en;
   logic     valid_ff [0:DEPTH-1];
   side_type side_ff  [0:DEPTH-1];
   side_type side_in;
   side_type mul_merge;
   side_type last;

   logic signed [DATA_W-1:0] a;
   logic signed [DATA_W-1:0] b;
   logic signed [DATA_W-1:0] mul_out;
   logic signed [DATA_W-1:0] div_out;
   op_type                   op;
   logic                     lt;
   logic                     eq;

   // stall only when a shown response is not taken
   assign en             = !valid_ff[DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      a  = req_chan.operand_a;
      b  = req_chan.operand_b;
      op = op_type'(req_chan.op);
      lt = a < b;
      eq = a == b;
      side_in                = '0;
      side_in.op             = op;
      case (op)
         OP_ADD:      side_in.value = a + b;
         OP_SUB:      side_in.value = a - b;
         OP_MUL:      side_in.value = '0;
         OP_DIV:      side_in.divide_by_zero = (b == '0);
         OP_LT:       side_in.compare_true = lt;
         OP_GT:       side_in.compare_true = !lt && !eq;
         OP_LE:       side_in.compare_true = lt || eq;
         OP_GE:       side_in.compare_true = !lt;
         OP_EQ:       side_in.compare_true = eq;
         OP_NE:       side_in.compare_true = !eq;
         OP_MIN:      side_in.value = (lt || eq) ? a : b;
         OP_MAX:      side_in.value = !lt ? a : b;
         OP_INC:      side_in.value = a + DATA_W'(1);
         OP_DEC:      side_in.value = a - DATA_W'(1);
         OP_FROM_INT: side_in.value = a <<< FRACTION_BITS;
         OP_TO_INT:   side_in.value = a >>> FRACTION_BITS;
         default:     side_in.value = '0;
      endcase
   end

   q24_alu_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock   (clock),
      .en      (en),
      .a       (a),
      .b       (b),
      .product (mul_out)
   );

   q24_alu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock    (clock),
      .en       (en),
      .a        (a),
      .b        (b),
      .quotient (div_out)
   );

   // product lands in the side pipeline once the multiplier output lines up
   always_comb begin
      mul_merge = side_ff[MUL_LAT-1];
      if (side_ff[MUL_LAT-1].op == OP_MUL) begin
         mul_merge.value = mul_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_chan.valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DEPTH; i++) begin
            side_ff[i] <= (i == MUL_LAT) ? mul_merge : side_ff[i-1];
         end
      end
   end

   always_comb begin
      last = side_ff[DEPTH-1];
      if (last.op == OP_DIV && !last.divide_by_zero) begin
         last.value = div_out;
      end
   end

   assign rsp_chan.valid          = valid_ff[DEPTH-1];
   assign rsp_chan.result_value   = last.value;
   assign rsp_chan.compare_true   = last.compare_true;
   assign rsp_chan.divide_by_zero = last.divide_by_zero;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.divide_by_zero |-> rsp_chan.result_value == '0)
      else $error("divide by zero with nonzero result");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.compare_true |->
         rsp_chan.result_value == '0 && !rsp_chan.divide_by_zero)
      else $error("compare response carries value or divide flag");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while pipeline is stalled");

endmodule

// ===== tb/tb_fixed_point_q24_8_alu.sv =====
// self-checking testbench for the q24.8 fixed-point alu: directed table, then random requests
// depends on q24_alu_pkg, q24_alu_if and fixed_point_q24_8_alu
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu;
   import q24_alu_pkg::*;

   localparam int FRAC     = 8;
   localparam int N_RAND   = 1300;
   localparam int LATENCY  = FRAC + 34;
   localparam int MAX_CYC  = 400000;
   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               cmp;
      logic               dz;
   } alu_result_type;

   typedef struct {
      op_type             op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               typed;
      alu_result_type     res;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   int   errors = 0;
   alu_result_type expected_q[$];

   q24_alu_req_if req_chan();
   q24_alu_rsp_if rsp_chan();

   fixed_point_q24_8_alu #(.FRACTION_BITS(FRAC)) uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   function automatic alu_result_type compute_alu(op_type op, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type r;
      logic signed [63:0] prod;
      logic signed [63:0] num;
      logic signed [63:0] quo;
      r = '0;
      case (op)
         OP_ADD: r.value = a + b;
         OP_SUB: r.value = a - b;
         OP_MUL: begin
            prod = 64'(a) * 64'(b);
            r.value = prod[FRAC +: 32];
         end
         OP_DIV: begin
            if (b == 0) r.dz = 1'b1;
            else begin
               num = 64'(a) <<< FRAC;
               quo = num / 64'(b);
               r.value = quo[31:0];
            end
         end
         OP_LT: r.cmp = a < b;
         OP_GT: r.cmp = a > b;
         OP_LE: r.cmp = a <= b;
         OP_GE: r.cmp = a >= b;
         OP_EQ: r.cmp = a == b;
         OP_NE: r.cmp = a != b;
         OP_MIN: r.value = (a <= b) ? a : b;
         OP_MAX: r.value = (a >= b) ? a : b;
         OP_INC: r.value = a + 1;
         OP_DEC: r.value = a - 1;
         OP_FROM_INT: r.value = a <<< FRAC;
         default: r.value = a >>> FRAC;
      endcase
      return r;
   endfunction

   function automatic alu_result_type mk(logic signed [31:0] v, logic c, logic d);
      alu_result_type r;
      r.value = v;
      r.cmp = c;
      r.dz = d;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? MAXV : MINV;
         1: return $signed(32'($urandom_range(0, 8)) - 32'd4);
         2: return $signed(32'($urandom_range(0, 65535)) - 32'd32768);
         default: return $signed($urandom());
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= MAX_CYC) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver stalls on a rotating pattern: always ready, then random ready in most cycles, then random ready in few
   int stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[9:8] == 2'd0) rsp_chan.ready <= 1'b1;
         else if (stall_phase[9:8] == 2'd1) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         else rsp_chan.ready <= ($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      alu_result_type got;
      alu_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = mk(rsp_chan.result_value, rsp_chan.compare_true, rsp_chan.divide_by_zero);
         if (expected_q.size() == 0) begin
            $error("unexpected response value %h", got.value);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got.value !== want.value) begin
               $error("result_value expected %h actual %h", want.value, got.value);
               errors++;
            end
            if (got.cmp !== want.cmp) begin
               $error("compare_true expected %b actual %b", want.cmp, got.cmp);
               errors++;
            end
            if (got.dz !== want.dz) begin
               $error("divide_by_zero expected %b actual %b", want.dz, got.dz);
               errors++;
            end
         end
      end
   end

   task automatic send_request(op_type op, logic signed [31:0] a, logic signed [31:0] b,
                               alu_result_type res);
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_q.push_back(res);
   endtask

   // sender gaps between bursts; valid stays high within a burst
   task automatic idle_gap();
      int gap;
      gap = $urandom_range(1, 6);
      req_chan.valid     <= 1'b0;
      req_chan.operand_a <= $signed($urandom());
      req_chan.operand_b <= $signed($urandom());
      repeat (gap) @(posedge clock);
   endtask

   stim_row_type table_rows[$];
   int burst_left;

   initial begin
      stim_row_type row;
      op_type op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      int wait_cyc;

      req_chan.valid = 1'b0;
      req_chan.op = OP_ADD;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;

      table_rows = '{
         '{OP_ADD, MAXV, 32'sd1, 1'b1, mk(MINV, 0, 0)},
         '{OP_SUB, MINV, 32'sd1, 1'b1, mk(MAXV, 0, 0)},
         '{OP_MUL, 32'sh100, 32'sh100, 1'b1, mk(32'sh100, 0, 0)},
         '{OP_MUL, MAXV, MAXV, 1'b0, '0},
         '{OP_MUL, MINV, MINV, 1'b0, '0},
         '{OP_MUL, -32'sd1, 32'sd1, 1'b1, mk(-32'sd1, 0, 0)},
         '{OP_DIV, 32'sh100, 32'sd0, 1'b1, mk(32'sd0, 0, 1)},
         '{OP_DIV, MINV, -32'sd1, 1'b0, '0},
         '{OP_DIV, MAXV, 32'sd1, 1'b0, '0},
         '{OP_DIV, -32'sd3, 32'sh200, 1'b0, '0},
         '{OP_LT, MINV, MAXV, 1'b1, mk(0, 1, 0)},
         '{OP_GT, MINV, MAXV, 1'b1, mk(0, 0, 0)},
         '{OP_LE, 32'sd5, 32'sd5, 1'b1, mk(0, 1, 0)},
         '{OP_GE, -32'sd1, 32'sd0, 1'b1, mk(0, 0, 0)},
         '{OP_EQ, MAXV, MAXV, 1'b1, mk(0, 1, 0)},
         '{OP_NE, MAXV, MAXV, 1'b1, mk(0, 0, 0)},
         '{OP_MIN, MINV, MAXV, 1'b1, mk(MINV, 0, 0)},
         '{OP_MAX, MINV, MAXV, 1'b1, mk(MAXV, 0, 0)},
         '{OP_MIN, 32'sd7, 32'sd7, 1'b1, mk(32'sd7, 0, 0)},
         '{OP_INC, MAXV, MINV, 1'b1, mk(MINV, 0, 0)},
         '{OP_DEC, MINV, MAXV, 1'b1, mk(MAXV, 0, 0)},
         '{OP_FROM_INT, MAXV, 32'sd0, 1'b1, mk(32'shffffff00, 0, 0)},
         '{OP_TO_INT, -32'sd1, -32'sd1, 1'b1, mk(-32'sd1, 0, 0)},
         '{OP_TO_INT, MINV, 32'sd0, 1'b1, mk(32'shff800000, 0, 0)}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         row = table_rows[i];
         send_request(row.op, row.a, row.b,
                      row.typed ? row.res : compute_alu(row.op, row.a, row.b));
         if ($urandom_range(0, 3) == 0) idle_gap();
      end

      burst_left = 0;
      for (int n = 0; n < N_RAND; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (n > N_RAND / 3) idle_gap();
         end
         burst_left--;
         op = op_type'($urandom_range(0, 15));
         a = rand_operand();
         b = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_operand();
         send_request(op, a, b, compute_alu(op, a, b));
      end
      req_chan.valid <= 1'b0;

      wait_cyc = 0;
      while (expected_q.size() != 0 && wait_cyc < 200000) begin
         @(posedge clock);
         wait_cyc++;
      end
      repeat (2 * LATENCY) @(posedge clock);

      if (errors == 0 && expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== fixed_point_q24_8_alu.f =====
rtl/core/q24_alu_pkg.sv
rtl/core/q24_alu_if.sv
rtl/core/q24_alu_mul.sv
rtl/core/q24_alu_div.sv
rtl/core/fixed_point_q24_8_alu.sv
tb/tb_fixed_point_q24_8_alu.sv
